### hdl/myers_sequence_diff_macros.svh
// Assertion macros used by the diff engine checker.
// Depends on nothing; included by the checker file.
`ifndef MYERS_SEQUENCE_DIFF_MACROS_SVH
`define MYERS_SEQUENCE_DIFF_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define MSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("diff engine check failed");

// Next-cycle implication, reset masks the check.
`define MSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("diff engine check failed");

`endif

### hdl/msd_pkg.sv
// Shared types and codes for the shortest-edit-script diff engine.
// No dependencies; used by the top level and its checker.
package msd_pkg;

    localparam int MAX_LEN_DEF    = 32;
    localparam int TOKEN_BITS_DEF = 32;

    localparam logic [1:0] KIND_OLD = 2'd0;
    localparam logic [1:0] KIND_NEW = 2'd1;
    localparam logic [1:0] KIND_RUN = 2'd2;
    localparam logic [1:0] KIND_NOP = 2'd3;

    localparam logic [1:0] OP_DEL   = 2'd0;
    localparam logic [1:0] OP_INS   = 2'd1;
    localparam logic [1:0] OP_EQUAL = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRE_RD,
        ST_PRE_CMP,
        ST_SUF_RD,
        ST_SUF_CMP,
        ST_SETUP,
        ST_K_RD,
        ST_K_SEL,
        ST_SN_RD,
        ST_SN_CMP,
        ST_K_END,
        ST_B_A,
        ST_B_B,
        ST_B_C,
        ST_E_RD,
        ST_E_OUT
    } state_t;

endpackage

### hdl/myers_sequence_diff.sv
// Shortest-edit-script diff engine: token stores, front history, edit list.
// Depends on msd_pkg.
//
// Usage: drive kind and token with start high while busy is low; that edge is
// the transfer. kind 0 appends token to the old sequence, kind 1 to the new
// sequence; busy stays low through a load, so loads may follow
// back to back. A load into a full store is dropped and sets the overflow flag.
// kind 2 runs the diff: busy rises the next cycle and falls in the cycle that
// carries the last result. Results appear as one-cycle strobes carrying op,
// position, last and overflow; the receiver cannot stall and must take each.
// A run strips the common prefix and suffix one element at a time, then visits
// the diagonals of each front in turn, following the matching steps along each;
// it then backtracks one edit at a time and emits the results.
// Equal sequences give one result with op 2 in the cycle after the setup cycle
// that follows the stripping.
// Reset clears the counts, the overflow flag and the sequencer; the memories
// need no clearing since every entry that a run uses is written before it is read.
module myers_sequence_diff #(
    parameter int MAX_LEN    = msd_pkg::MAX_LEN_DEF,
    parameter int TOKEN_BITS = msd_pkg::TOKEN_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] token,
    output logic        strobe,
    output logic [1:0]  op,
    output logic [4:0]  position,
    output logic        last,
    output logic        overflow
);

    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int HW    = 2 * MAX_LEN + 1;
    localparam int D_W   = $clog2(HW);
    localparam int SW    = D_W + 3;
    localparam int HDEP  = HW * HW;
    localparam int HA_W  = $clog2(HDEP);
    localparam int EDEP  = 2 * MAX_LEN;
    localparam int EI_W  = (EDEP > 1) ? $clog2(EDEP) : 1;
    localparam int EW    = 7;

    logic [TOKEN_BITS-1:0] old_mem [MAX_LEN];
    logic [TOKEN_BITS-1:0] new_mem [MAX_LEN];
    logic [LEN_W-1:0]      hist_mem [HDEP];
    logic [EW-1:0]         edit_mem [EDEP];

    logic [TOKEN_BITS-1:0] old_q, new_q;
    logic [LEN_W-1:0]      hist_q;
    logic [EW-1:0]         edit_q;

    msd_pkg::state_t state_reg, state_next;
    logic [LEN_W-1:0] old_cnt_reg, old_cnt_next;
    logic [LEN_W-1:0] new_cnt_reg, new_cnt_next;
    logic             dropped_reg, dropped_next;
    logic [LEN_W-1:0] pre_reg, pre_next;
    logic [LEN_W-1:0] suf_reg, suf_next;
    logic [LEN_W-1:0] n2_reg, n2_next;
    logic [LEN_W-1:0] m2_reg, m2_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic [D_W-1:0]   j_reg, j_next;
    logic signed [SW-1:0] k_reg, k_next;
    logic signed [SW-1:0] x_reg, x_next;
    logic signed [SW-1:0] y_reg, y_next;
    logic [LEN_W-1:0] vprev_reg, vprev_next;
    logic [LEN_W-1:0] vlo_reg, vlo_next;
    logic [HA_W-1:0]  hbase_reg, hbase_next;
    logic [HA_W-1:0]  rbase_reg, rbase_next;
    logic [D_W-1:0]   cnt_reg, cnt_next;
    logic [EI_W-1:0]  s_reg, s_next;
    logic             strobe_reg, strobe_next;
    logic [1:0]       op_reg, op_next;
    logic [4:0]       pos_reg, pos_next;
    logic             last_reg, last_next;
    logic             ovf_reg, ovf_next;

    logic                  old_we, new_we, hist_we, edit_we;
    logic [TOKEN_BITS-1:0] tok_val;
    logic [63:0]           tok_ext;
    logic [IDX_W-1:0]      old_raddr, new_raddr;
    logic [HA_W-1:0]       hist_raddr, hist_waddr;
    logic [LEN_W-1:0]      hist_wdata;
    logic [EW-1:0]         edit_wdata;

    logic signed [SW-1:0] d_s, n_s, m_s, pre_s, suf_s, n2_s, m2_s;
    logic signed [SW-1:0] hist_v, vprev_s, vlo_s, y_cur, sum_ox, sum_ny;
    logic signed [SW-1:0] xs, k_bt, jb_s, pk, px, py, pos_s;
    logic                 take_ins, toks_eq;

    assign tok_ext = {32'd0, token};
    assign tok_val = tok_ext[TOKEN_BITS-1:0];

    assign d_s     = $signed(SW'(d_reg));
    assign n_s     = $signed(SW'(old_cnt_reg));
    assign m_s     = $signed(SW'(new_cnt_reg));
    assign pre_s   = $signed(SW'(pre_reg));
    assign suf_s   = $signed(SW'(suf_reg));
    assign n2_s    = $signed(SW'(n2_reg));
    assign m2_s    = $signed(SW'(m2_reg));
    assign hist_v  = $signed(SW'(hist_q));
    assign vprev_s = $signed(SW'(vprev_reg));
    assign vlo_s   = $signed(SW'(vlo_reg));
    assign y_cur   = x_reg - k_reg;
    assign sum_ox  = pre_s + x_reg;
    assign sum_ny  = pre_s + y_cur;
    assign k_bt    = x_reg - y_reg;
    assign jb_s    = (k_bt + d_s) >>> 1;
    assign toks_eq = (old_q == new_q);

    assign take_ins = (k_reg == -d_s) || ((k_reg != d_s) && (vlo_s < hist_v));
    assign px       = take_ins ? hist_v : vlo_s;
    assign pk       = take_ins ? (k_reg + SW'(1)) : (k_reg - SW'(1));
    assign py       = px - pk;
    assign pos_s    = take_ins ? (pre_s + py) : (pre_s + px);

    always_comb
    begin
        state_next   = state_reg;
        old_cnt_next = old_cnt_reg;
        new_cnt_next = new_cnt_reg;
        dropped_next = dropped_reg;
        pre_next     = pre_reg;
        suf_next     = suf_reg;
        n2_next      = n2_reg;
        m2_next      = m2_reg;
        d_next       = d_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        vprev_next   = vprev_reg;
        vlo_next     = vlo_reg;
        hbase_next   = hbase_reg;
        rbase_next   = rbase_reg;
        cnt_next     = cnt_reg;
        s_next       = s_reg;
        strobe_next  = 1'b0;
        op_next      = op_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        old_we       = 1'b0;
        new_we       = 1'b0;
        hist_we      = 1'b0;
        edit_we      = 1'b0;
        old_raddr    = pre_reg[IDX_W-1:0];
        new_raddr    = pre_reg[IDX_W-1:0];
        hist_raddr   = rbase_reg + HA_W'(j_reg);
        hist_waddr   = hbase_reg + HA_W'(j_reg);
        hist_wdata   = x_reg[LEN_W-1:0];
        edit_wdata   = {take_ins ? msd_pkg::OP_INS : msd_pkg::OP_DEL, pos_s[4:0]};
        xs           = x_reg;

        case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        msd_pkg::KIND_OLD:
                        begin
                            if (old_cnt_reg < LEN_W'(MAX_LEN))
                            begin
                                old_we       = 1'b1;
                                old_cnt_next = old_cnt_reg + LEN_W'(1);
                            end
                            else
                                dropped_next = 1'b1;
                        end
                        msd_pkg::KIND_NEW:
                        begin
                            if (new_cnt_reg < LEN_W'(MAX_LEN))
                            begin
                                new_we       = 1'b1;
                                new_cnt_next = new_cnt_reg + LEN_W'(1);
                            end
                            else
                                dropped_next = 1'b1;
                        end
                        msd_pkg::KIND_RUN:
                        begin
                            pre_next   = '0;
                            suf_next   = '0;
                            cnt_next   = '0;
                            state_next = msd_pkg::ST_PRE_RD;
                        end
                        default: ;
                    endcase
                end
            end
            msd_pkg::ST_PRE_RD:
            begin
                if (pre_reg < old_cnt_reg && pre_reg < new_cnt_reg)
                    state_next = msd_pkg::ST_PRE_CMP;
                else
                    state_next = msd_pkg::ST_SUF_RD;
            end
            msd_pkg::ST_PRE_CMP:
            begin
                if (toks_eq)
                begin
                    pre_next   = pre_reg + LEN_W'(1);
                    state_next = msd_pkg::ST_PRE_RD;
                end
                else
                    state_next = msd_pkg::ST_SUF_RD;
            end
            msd_pkg::ST_SUF_RD:
            begin
                old_raddr = IDX_W'(n_s - SW'(1) - suf_s);
                new_raddr = IDX_W'(m_s - SW'(1) - suf_s);
                if (suf_s < n_s - pre_s && suf_s < m_s - pre_s)
                    state_next = msd_pkg::ST_SUF_CMP;
                else
                    state_next = msd_pkg::ST_SETUP;
            end
            msd_pkg::ST_SUF_CMP:
            begin
                if (toks_eq)
                begin
                    suf_next   = suf_reg + LEN_W'(1);
                    state_next = msd_pkg::ST_SUF_RD;
                end
                else
                    state_next = msd_pkg::ST_SETUP;
            end
            msd_pkg::ST_SETUP:
            begin
                n2_next    = old_cnt_reg - pre_reg - suf_reg;
                m2_next    = new_cnt_reg - pre_reg - suf_reg;
                d_next     = '0;
                j_next     = '0;
                k_next     = '0;
                hbase_next = '0;
                rbase_next = '0;
                if (old_cnt_reg == pre_reg + suf_reg && new_cnt_reg == pre_reg + suf_reg)
                begin
                    strobe_next  = 1'b1;
                    op_next      = msd_pkg::OP_EQUAL;
                    pos_next     = '0;
                    last_next    = 1'b1;
                    ovf_next     = dropped_reg;
                    old_cnt_next = '0;
                    new_cnt_next = '0;
                    dropped_next = 1'b0;
                    state_next   = msd_pkg::ST_IDLE;
                end
                else
                    state_next = msd_pkg::ST_K_RD;
            end
            msd_pkg::ST_K_RD:
                state_next = msd_pkg::ST_K_SEL;
            msd_pkg::ST_K_SEL:
            begin
                if (d_reg == '0)
                    xs = '0;
                else if (k_reg == -d_s)
                    xs = hist_v;
                else if (k_reg == d_s)
                    xs = vprev_s + SW'(1);
                else if (vprev_s < hist_v)
                    xs = hist_v;
                else
                    xs = vprev_s + SW'(1);
                x_next     = xs;
                vprev_next = hist_q;
                state_next = msd_pkg::ST_SN_RD;
            end
            msd_pkg::ST_SN_RD:
            begin
                old_raddr = sum_ox[IDX_W-1:0];
                new_raddr = sum_ny[IDX_W-1:0];
                if (x_reg < n2_s && y_cur >= 0 && y_cur < m2_s)
                    state_next = msd_pkg::ST_SN_CMP;
                else
                    state_next = msd_pkg::ST_K_END;
            end
            msd_pkg::ST_SN_CMP:
            begin
                if (toks_eq)
                begin
                    x_next     = x_reg + SW'(1);
                    state_next = msd_pkg::ST_SN_RD;
                end
                else
                    state_next = msd_pkg::ST_K_END;
            end
            msd_pkg::ST_K_END:
            begin
                hist_we = 1'b1;
                if (x_reg >= n2_s && y_cur >= m2_s)
                begin
                    x_next     = n2_s;
                    y_next     = m2_s;
                    state_next = msd_pkg::ST_B_A;
                end
                else if (k_reg == d_s)
                begin
                    d_next     = d_reg + D_W'(1);
                    k_next     = -(d_s + SW'(1));
                    j_next     = '0;
                    rbase_next = hbase_reg;
                    hbase_next = hbase_reg + HA_W'(HW);
                    state_next = msd_pkg::ST_K_RD;
                end
                else
                begin
                    k_next     = k_reg + SW'(2);
                    j_next     = j_reg + D_W'(1);
                    state_next = msd_pkg::ST_K_RD;
                end
            end
            msd_pkg::ST_B_A:
            begin
                k_next     = k_bt;
                j_next     = jb_s[D_W-1:0];
                hist_raddr = rbase_reg + HA_W'((k_bt == -d_s) ? jb_s : (jb_s - SW'(1)));
                if (d_reg == '0 || k_bt < -d_s || k_bt > d_s)
                begin
                    if (cnt_reg == '0)
                    begin
                        old_cnt_next = '0;
                        new_cnt_next = '0;
                        dropped_next = 1'b0;
                        state_next   = msd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        s_next     = EI_W'(cnt_reg - D_W'(1));
                        state_next = msd_pkg::ST_E_RD;
                    end
                end
                else
                    state_next = msd_pkg::ST_B_B;
            end
            msd_pkg::ST_B_B:
            begin
                vlo_next   = hist_q;
                state_next = msd_pkg::ST_B_C;
            end
            msd_pkg::ST_B_C:
            begin
                edit_we    = 1'b1;
                cnt_next   = cnt_reg + D_W'(1);
                x_next     = px;
                y_next     = py;
                d_next     = d_reg - D_W'(1);
                rbase_next = rbase_reg - HA_W'(HW);
                if (d_reg == D_W'(1))
                begin
                    s_next     = EI_W'(cnt_reg);
                    state_next = msd_pkg::ST_E_RD;
                end
                else
                    state_next = msd_pkg::ST_B_A;
            end
            msd_pkg::ST_E_RD:
                state_next = msd_pkg::ST_E_OUT;
            msd_pkg::ST_E_OUT:
            begin
                strobe_next = 1'b1;
                op_next     = edit_q[EW-1:5];
                pos_next    = edit_q[4:0];
                last_next   = (s_reg == '0);
                ovf_next    = dropped_reg;
                if (s_reg == '0)
                begin
                    old_cnt_next = '0;
                    new_cnt_next = '0;
                    dropped_next = 1'b0;
                    state_next   = msd_pkg::ST_IDLE;
                end
                else
                begin
                    s_next     = s_reg - EI_W'(1);
                    state_next = msd_pkg::ST_E_RD;
                end
            end
            default:
                state_next = msd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= msd_pkg::ST_IDLE;
            old_cnt_reg <= '0;
            new_cnt_reg <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            old_cnt_reg <= old_cnt_next;
            new_cnt_reg <= new_cnt_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg   <= pre_next;
        suf_reg   <= suf_next;
        n2_reg    <= n2_next;
        m2_reg    <= m2_next;
        d_reg     <= d_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        vprev_reg <= vprev_next;
        vlo_reg   <= vlo_next;
        hbase_reg <= hbase_next;
        rbase_reg <= rbase_next;
        cnt_reg   <= cnt_next;
        s_reg     <= s_next;
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
        ovf_reg   <= ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (old_we)
            old_mem[old_cnt_reg[IDX_W-1:0]] <= tok_val;
        if (new_we)
            new_mem[new_cnt_reg[IDX_W-1:0]] <= tok_val;
        old_q <= old_mem[old_raddr];
        new_q <= new_mem[new_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (edit_we)
            edit_mem[cnt_reg[EI_W-1:0]] <= edit_wdata;
        edit_q <= edit_mem[s_reg];
    end

    assign busy     = (state_reg != msd_pkg::ST_IDLE);
    assign strobe   = strobe_reg;
    assign op       = op_reg;
    assign position = pos_reg;
    assign last     = last_reg;
    assign overflow = ovf_reg;

endmodule

### hdl/msd_checker.sv
// Port-level checks on run starts and result transfers of the diff engine, and its bind.
// Depends on msd_pkg and myers_sequence_diff_macros.svh.
`include "myers_sequence_diff_macros.svh"

module msd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] kind,
    input logic       strobe,
    input logic [1:0] op,
    input logic [4:0] position,
    input logic       last
);

    `MSD_ASSERT_NOW(a_mid_busy, clk, rst_n, strobe && !last, busy)
    `MSD_ASSERT_NOW(a_equal_last, clk, rst_n, strobe && op == msd_pkg::OP_EQUAL, last)
    `MSD_ASSERT_NOW(a_equal_pos, clk, rst_n, strobe && op == msd_pkg::OP_EQUAL, position == 5'd0)
    `MSD_ASSERT_NEXT(a_run_busy, clk, rst_n, start && !busy && kind == msd_pkg::KIND_RUN, busy)

endmodule

bind myers_sequence_diff msd_checker u_msd_checker (.*);

### verif/myers_sequence_diff_tb.sv
// Self-checking bench for the shortest-edit-script diff engine: directed table, full stores, then
// bursts of random loads and runs, each result checked against an in-bench edit-script predictor.
// Depends on msd_pkg and myers_sequence_diff.
module myers_sequence_diff_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] position;
        logic       last;
        logic       overflow;
    } edit_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] token;
        bit          typed;
        edit_t       want;
    } row_t;

    logic        clk, rst_n, start, busy, strobe, last, overflow;
    logic [1:0]  kind, op;
    logic [31:0] token;
    logic [4:0]  position;

    logic [31:0] seq_old [CAP];
    logic [31:0] seq_new [CAP];
    int          n_old, n_new;
    bit          lost;
    edit_t       pending_edits [$];
    int          fails, idle_cycles;
    bit          timed_out;
    row_t        plan [$];

    myers_sequence_diff uut (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic void predict_edits(output edit_t res [$]);
        int pre, suf, n2, m2, found, x, y, k, pk, px, py, cnt;
        int front [129];
        int hist [65][129];
        bit done;
        edit_t rev [$];
        res = {};
        pre = 0; suf = 0; found = 0; done = 0;
        while (pre < n_old && pre < n_new && seq_old[pre] == seq_new[pre])
            pre++;
        while (suf < n_old - pre && suf < n_new - pre &&
               seq_old[n_old-1-suf] == seq_new[n_new-1-suf])
            suf++;
        n2 = n_old - pre - suf;
        m2 = n_new - pre - suf;
        if (n2 == 0 && m2 == 0)
        begin
            res.push_back('{msd_pkg::OP_EQUAL, 5'd0, 1'b1, lost});
            return;
        end
        foreach (front[i]) front[i] = 0;
        for (int d = 0; d <= n2 + m2 && !done; d++)
        begin
            hist[d] = front;
            for (k = -d; k <= d; k += 2)
            begin
                if (k == -d || (k != d && front[k+63] < front[k+65]))
                    x = front[k+65];
                else
                    x = front[k+63] + 1;
                y = x - k;
                while (x >= 0 && y >= 0 && x < n2 && y < m2 &&
                       seq_old[pre+x] == seq_new[pre+y])
                begin
                    x++;
                    y++;
                end
                front[k+64] = x;
                if (x >= n2 && y >= m2)
                begin
                    found = d;
                    done = 1;
                    break;
                end
            end
        end
        x = n2; y = m2;
        for (int d = found; d > 0; d--)
        begin
            k = x - y;
            if (k < -d || k > d) break;
            if (k == -d || (k != d && hist[d][k+63] < hist[d][k+65]))
                pk = k + 1;
            else
                pk = k - 1;
            px = hist[d][pk+64];
            py = px - pk;
            if (pk == k + 1)
                rev.push_front('{msd_pkg::OP_INS, 5'(pre + py), 1'b0, lost});
            else
                rev.push_front('{msd_pkg::OP_DEL, 5'(pre + px), 1'b0, lost});
            x = px; y = py;
        end
        cnt = rev.size();
        if (cnt > 0)
            rev[cnt-1].last = 1'b1;
        res = rev;
    endfunction

    function automatic void account_for(logic [1:0] kd, logic [31:0] tk);
        edit_t res [$];
        case (kd)
            msd_pkg::KIND_OLD: if (n_old < CAP) seq_old[n_old++] = tk; else lost = 1;
            msd_pkg::KIND_NEW: if (n_new < CAP) seq_new[n_new++] = tk; else lost = 1;
            msd_pkg::KIND_RUN:
            begin
                predict_edits(res);
                foreach (res[i]) pending_edits.push_back(res[i]);
                n_old = 0; n_new = 0; lost = 0;
            end
            default: ;
        endcase
    endfunction

    // Hold start after the transfer; the next transfer or an idle step drives it
    task automatic transfer(logic [1:0] kd, logic [31:0] tk);
        start <= 1; kind <= kd; token <= tk;
        @(posedge clk);
        while (busy) @(posedge clk);
        account_for(kd, tk);
        @(negedge clk);
    endtask

    task automatic add_row(logic [1:0] kd, logic [31:0] tk);
        plan.push_back('{kd, tk, 1'b0, '0});
    endtask

    task automatic add_run_typed(edit_t w);
        plan.push_back('{msd_pkg::KIND_RUN, 32'd0, 1'b1, w});
    endtask

    task automatic wait_drained();
        start <= 0;
        while (pending_edits.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // One random sequence pair, sometimes over the store size, mostly with a small alphabet so edits stay short
    task automatic random_pair();
        int lo, ln, alpha;
        lo = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 34 : 10);
        ln = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 34 : 10);
        alpha = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < lo + ln; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                start <= 0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            transfer((i < lo) ? msd_pkg::KIND_OLD : msd_pkg::KIND_NEW,
                     alpha == 0 ? $urandom() : 32'($urandom_range(0, alpha)));
        end
        if ($urandom_range(0, 15) == 0) transfer(msd_pkg::KIND_NOP, $urandom());
        transfer(msd_pkg::KIND_RUN, $urandom());
    endtask

    always @(posedge clk)
    begin
        edit_t got, want;
        if (rst_n && strobe)
        begin
            got = '{op, position, last, overflow};
            if (pending_edits.size() == 0)
            begin
                $error("unexpected result op=%0d position=%0d", op, position);
                fails++;
            end
            else
            begin
                want = pending_edits.pop_front();
                if (got.op !== want.op)
                begin
                    $error("op expected %0d actual %0d", want.op, got.op); fails++;
                end
                if (got.position !== want.position)
                begin
                    $error("position expected %0d actual %0d", want.position, got.position);
                    fails++;
                end
                if (got.last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, got.last); fails++;
                end
                if (got.overflow !== want.overflow)
                begin
                    $error("overflow expected %0d actual %0d", want.overflow, got.overflow);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        fails = 0; idle_cycles = 0; timed_out = 0;
        n_old = 0; n_new = 0; lost = 0;
        rst_n = 0; start = 0; kind = msd_pkg::KIND_OLD; token = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        add_run_typed('{msd_pkg::OP_EQUAL, 5'd0, 1'b1, 1'b0});
        add_row(msd_pkg::KIND_OLD, 32'hFFFF_FFFF);
        add_run_typed('{msd_pkg::OP_DEL, 5'd0, 1'b1, 1'b0});
        add_row(msd_pkg::KIND_NEW, 32'h0000_0000);
        add_run_typed('{msd_pkg::OP_INS, 5'd0, 1'b1, 1'b0});
        add_row(msd_pkg::KIND_OLD, 32'h5555_AAAA);
        add_row(msd_pkg::KIND_NEW, 32'h5555_AAAA);
        add_row(msd_pkg::KIND_NOP, 32'h1234_5678);
        add_run_typed('{msd_pkg::OP_EQUAL, 5'd0, 1'b1, 1'b0});
        add_row(msd_pkg::KIND_OLD, 32'hAAAA_5555);
        add_row(msd_pkg::KIND_OLD, 32'h1);
        add_row(msd_pkg::KIND_NEW, 32'h2);
        add_row(msd_pkg::KIND_NEW, 32'hAAAA_5555);
        add_run_typed('{msd_pkg::OP_INS, 5'd0, 1'b0, 1'b0});
        foreach (plan[i])
        begin
            transfer(plan[i].kind, plan[i].token);
            if (plan[i].typed && pending_edits[0] != plan[i].want)
            begin
                $error("row %0d op expected %0d actual %0d, position expected %0d actual %0d",
                       i, plan[i].want.op, pending_edits[0].op,
                       plan[i].want.position, pending_edits[0].position);
                fails++;
            end
        end
        wait_drained();

        // Full stores plus dropped loads, every position used
        for (int i = 0; i < 33; i++) transfer(msd_pkg::KIND_OLD, 32'(i));
        for (int i = 0; i < 33; i++) transfer(msd_pkg::KIND_NEW, 32'(i + 100));
        transfer(msd_pkg::KIND_RUN, 32'hFFFF_FFFF);
        wait_drained();

        for (int r = 0; r < 22; r++)
        begin
            random_pair();
            if (r % 8 == 0) wait_drained();
        end
        wait_drained();

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/msd_pkg.sv
hdl/myers_sequence_diff.sv
hdl/msd_checker.sv
verif/myers_sequence_diff_tb.sv
